// ===== hdl/rrts_pkg.sv =====
`timescale 1ns / 1ps
package rrts_pkg;

  // Command codes carried by the input beat.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Register select, taken from address bit 2.
  localparam logic REG_SLICE = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  // One process table entry as it travels around the ring of cells.
  typedef struct packed {
    logic [15:0] arr;
    logic [15:0] burst;
    logic [15:0] rem;
  } rrts_entry_t;

  // Controls from the sequencer to the ready queue.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } rrts_fifo_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_ALIGN,
    S_SCAN,
    S_CHECK,
    S_POP_REQ,
    S_POP_WAIT,
    S_POP_FIND,
    S_RUN,
    S_FINISH,
    S_EMIT
  } rrts_state_t;

endpackage

// ===== hdl/round_robin_time_slice_scheduler_core.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+----------------------------------------------
// cfg      | in/out    | psel/penable/pready   | paddr, pwdata, pwrite, prdata
// in       | in        | in_valid / in_ready   | command, proc_index, arrival_time, burst_time
// out      | out       | out_valid / out_ready | slot_busy ... all_done
//
// The process table lives in a ring of MAX_PROCS cells that rotates by one entry every cycle;
// the sequencer sees one entry at the ring head per cycle and may rewrite it on its way back.
// A load waits for its entry to reach the head. A tick is accepted, makes a table pass (align
// to entry 0, then sweep) and a check; if work remains, ready queue pops and a run step follow,
// then a second pass, finish and emit, else it emits at once; a clear is handled in the idle
// state.
// Reset is synchronous and restores the registers and the scheduling state; table contents
// are undefined until loaded. A result waits in the output register while new beats are taken;
// the next tick holds in its final state until that register is free.
module round_robin_time_slice_scheduler_core #(
  parameter int MAX_PROCS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [5:0]  proc_index,
  input  logic [15:0] arrival_time,
  input  logic [15:0] burst_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        slot_busy,
  output logic [5:0]  slot_process,
  output logic [31:0] time_now,
  output logic        finished,
  output logic [5:0]  finished_process,
  output logic [31:0] finish_time,
  output logic [31:0] wait_time,
  output logic [31:0] turnaround_time,
  output logic        all_done
);
  import rrts_pkg::*;

  localparam int IW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW_N = $clog2(MAX_PROCS + 1);
  localparam int CW   = (CW_N > 7) ? CW_N : 7;

  // Configuration registers.
  logic [7:0] slice_length;
  logic [6:0] proc_count;
  logic       cfg_wr;
  logic [7:0] quantum;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign quantum = (slice_length == 8'd0) ? 8'd1 : slice_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_length <= 8'd2;
      proc_count   <= 7'd0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_COUNT) begin
        proc_count <= pwdata[6:0];
      end else begin
        slice_length <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_COUNT) ? {25'd0, proc_count} : {24'd0, slice_length};

  // Ring of table cells. Entry head_idx sits in cell 0; the value fed to the last cell is the
  // head entry, possibly rewritten by a load or by the decrement of the running process.
  rrts_entry_t ring_q [MAX_PROCS];
  rrts_entry_t head;
  rrts_entry_t wrap;
  logic [IW-1:0] head_idx;

  assign head = ring_q[0];

  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    rrts_entry_t cell_in;
    if (i == MAX_PROCS - 1) begin : g_tail
      assign cell_in = wrap;
    end else begin : g_mid
      assign cell_in = ring_q[i+1];
    end
    rrts_cell u_cell (
      .clk      (clk),
      .entry_in (cell_in),
      .entry_out(ring_q[i])
    );
  end

  logic at_last;
  assign at_last = (head_idx == IW'(MAX_PROCS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      head_idx <= '0;
    end else begin
      head_idx <= at_last ? '0 : head_idx + 1'b1;
    end
  end

  // Ready queue.
  rrts_fifo_ctl_t fifo_ctl;
  logic [IW-1:0]  push_data;
  logic [IW-1:0]  rd_data;
  logic [CW-1:0]  fifo_count;

  rrts_fifo #(
    .DEPTH(MAX_PROCS),
    .IW   (IW),
    .CW   (CW)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .ctl      (fifo_ctl),
    .push_data(push_data),
    .rd_data  (rd_data),
    .count    (fifo_count)
  );

  // Scheduler state.
  rrts_state_t   state;
  rrts_state_t   state_next;
  logic          started;
  logic          running;
  logic [IW-1:0] cur;
  logic [IW-1:0] cand;
  logic [7:0]    slice_used;
  logic [31:0]   clock_time;
  logic          pass_b;
  logic          arr_en;
  logic          dec_en;
  logic          ran;
  logic          work_any;
  logic [15:0]   cur_rem;
  logic [15:0]   cur_arr;
  logic [15:0]   cur_burst;

  // Latched load beat.
  logic [5:0]  ld_idx;
  logic [15:0] ld_arr;
  logic [15:0] ld_burst;
  logic        ld_ok;

  // Pending result.
  logic        res_busy;
  logic [5:0]  res_proc;
  logic [31:0] res_time;
  logic        res_fin;
  logic [5:0]  res_fproc;
  logic [31:0] res_finish;
  logic [31:0] res_wait;
  logic [31:0] res_turn;
  logic        res_done;

  logic        in_use;
  logic        ld_hit;
  logic        arr_hit;
  logic        cur_hit;
  logic [31:0] turn_c;
  logic        out_load;

  // Only entries below the used count take part; head_idx never reaches MAX_PROCS, so the
  // count is clamped for free.
  assign in_use  = CW'(head_idx) < CW'(proc_count);
  assign ld_hit  = CW'(head_idx) == CW'(ld_idx);
  assign arr_hit = arr_en && in_use && ({16'd0, head.arr} == clock_time);
  assign cur_hit = head_idx == cur;
  assign turn_c  = clock_time - {16'd0, cur_arr};
  assign out_load = (state == S_EMIT) && (!out_valid || out_ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (command == CMD_LOAD) begin
            state_next = S_LOAD;
          end else if (command == CMD_TICK) begin
            state_next = S_ALIGN;
          end
        end
      end
      S_LOAD: begin
        if (ld_hit || !ld_ok) begin
          state_next = S_IDLE;
        end
      end
      S_ALIGN: begin
        if (at_last) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (at_last) begin
          state_next = pass_b ? S_FINISH : S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = work_any ? S_POP_REQ : S_EMIT;
      end
      S_POP_REQ: begin
        state_next = (!running && fifo_count != '0) ? S_POP_WAIT : S_RUN;
      end
      S_POP_WAIT: begin
        state_next = S_POP_FIND;
      end
      S_POP_FIND: begin
        if (head_idx == cand) begin
          state_next = S_POP_REQ;
        end
      end
      S_RUN: begin
        state_next = S_ALIGN;
      end
      S_FINISH: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Controls for the ring head and the ready queue.
  always_comb begin
    wrap      = head;
    fifo_ctl  = '0;
    push_data = head_idx;
    in_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready       = 1'b1;
        fifo_ctl.clear = in_valid && (command == CMD_CLEAR);
      end
      S_LOAD: begin
        if (ld_hit && ld_ok) begin
          wrap.arr   = ld_arr;
          wrap.burst = ld_burst;
          wrap.rem   = ld_burst;
        end
      end
      S_SCAN: begin
        if (dec_en && cur_hit) begin
          wrap.rem = head.rem - 16'd1;
        end
        fifo_ctl.push = arr_hit;
      end
      S_POP_REQ: begin
        fifo_ctl.pop = !running && (fifo_count != '0);
      end
      S_FINISH: begin
        // A preempted process goes behind the arrivals queued in the sweep just done.
        if (ran && cur_rem != 16'd0 && slice_used >= quantum) begin
          fifo_ctl.push = 1'b1;
          push_data     = cur;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      started    <= 1'b0;
      running    <= 1'b0;
      cur        <= '0;
      slice_used <= 8'd0;
      clock_time <= 32'd0;
      pass_b     <= 1'b0;
      arr_en     <= 1'b0;
      dec_en     <= 1'b0;
      ran        <= 1'b0;
      work_any   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (in_valid && command == CMD_CLEAR) begin
            started    <= 1'b0;
            running    <= 1'b0;
            cur        <= '0;
            slice_used <= 8'd0;
            clock_time <= 32'd0;
          end else if (in_valid && command == CMD_TICK) begin
            // The first tick after reset or clear queues the arrivals at the current time.
            pass_b  <= 1'b0;
            dec_en  <= 1'b0;
            arr_en  <= !started;
            started <= 1'b1;
          end
        end
        S_ALIGN: begin
          work_any <= 1'b0;
        end
        S_SCAN: begin
          if (in_use && wrap.rem != 16'd0) begin
            work_any <= 1'b1;
          end
        end
        S_CHECK: begin
          // A reload may have zeroed the running process; it then stops without a report.
          if (work_any && running && cur_rem == 16'd0) begin
            running <= 1'b0;
          end
        end
        S_POP_FIND: begin
          // Entries with no work left are dropped from the queue head.
          if (head_idx == cand && head.rem != 16'd0) begin
            cur        <= cand;
            running    <= 1'b1;
            slice_used <= 8'd0;
          end
        end
        S_RUN: begin
          ran    <= running;
          dec_en <= running;
          pass_b <= 1'b1;
          if (running) begin
            slice_used <= slice_used + 8'd1;
          end
          // Time saturates at its maximum, and such a time matches no arrival.
          if (clock_time != TIME_MAX) begin
            clock_time <= clock_time + 32'd1;
            arr_en     <= 1'b1;
          end else begin
            arr_en <= 1'b0;
          end
        end
        S_FINISH: begin
          if (ran && (cur_rem == 16'd0 || slice_used >= quantum)) begin
            running <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers of the datapath.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && command == CMD_LOAD) begin
      ld_idx   <= proc_index;
      ld_arr   <= arrival_time;
      ld_burst <= burst_time;
      ld_ok    <= CW'(proc_index) < CW'(MAX_PROCS);
    end
    if (state == S_SCAN && cur_hit) begin
      cur_rem   <= wrap.rem;
      cur_arr   <= head.arr;
      cur_burst <= head.burst;
    end
    if (state == S_POP_WAIT) begin
      cand <= rd_data;
    end
    if (state == S_CHECK && !work_any) begin
      res_busy   <= 1'b0;
      res_proc   <= 6'd0;
      res_time   <= clock_time;
      res_fin    <= 1'b0;
      res_fproc  <= 6'd0;
      res_finish <= 32'd0;
      res_wait   <= 32'd0;
      res_turn   <= 32'd0;
      res_done   <= 1'b1;
    end else if (state == S_FINISH) begin
      res_busy <= ran;
      res_proc <= ran ? 6'(cur) : 6'd0;
      res_time <= clock_time;
      res_done <= !work_any;
      if (ran && cur_rem == 16'd0) begin
        res_fin    <= 1'b1;
        res_fproc  <= 6'(cur);
        res_finish <= clock_time;
        res_turn   <= turn_c;
        res_wait   <= turn_c - {16'd0, cur_burst};
      end else begin
        res_fin    <= 1'b0;
        res_fproc  <= 6'd0;
        res_finish <= 32'd0;
        res_turn   <= 32'd0;
        res_wait   <= 32'd0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      slot_busy        <= res_busy;
      slot_process     <= res_proc;
      time_now         <= res_time;
      finished         <= res_fin;
      finished_process <= res_fproc;
      finish_time      <= res_finish;
      wait_time        <= res_wait;
      turnaround_time  <= res_turn;
      all_done         <= res_done;
    end
  end

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && at_last) |=> (state == S_CHECK || state == S_FINISH))
    else $error("table sweep did not end after the last entry");

  a_finish_stops: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && ran && cur_rem == 16'd0) |=> !running)
    else $error("finished process still marked running");

  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_valid && !out_ready) |=> (state == S_EMIT))
    else $error("result dropped while output register busy");

endmodule

// ===== hdl/rrts_cell.sv =====
`timescale 1ns / 1ps
module rrts_cell (
  input  logic                 clk,
  input  rrts_pkg::rrts_entry_t entry_in,
  output rrts_pkg::rrts_entry_t entry_out
);
  import rrts_pkg::*;

  // Each cell holds one table entry and passes it to its neighbor every cycle.
  always_ff @(posedge clk) begin
    entry_out <= entry_in;
  end

endmodule

// ===== hdl/rrts_fifo.sv =====
`timescale 1ns / 1ps
module rrts_fifo #(
  parameter int DEPTH = 64,
  parameter int IW    = 6,
  parameter int CW    = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rrts_pkg::rrts_fifo_ctl_t ctl,
  input  logic [IW-1:0]           push_data,
  output logic [IW-1:0]           rd_data,
  output logic [CW-1:0]           count
);
  import rrts_pkg::*;

  logic [IW-1:0] mem [DEPTH];
  logic [IW-1:0] head;
  logic [IW-1:0] tail;
  logic          do_push;

  // A push into a full queue is dropped.
  assign do_push = ctl.push && (count < CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= push_data;
    end
    if (ctl.pop) begin
      rd_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == IW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (ctl.pop) begin
        head <= (head == IW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (do_push && !ctl.pop) begin
        count <= count + 1'b1;
      end else if (ctl.pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("ready queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> (count != '0) && !ctl.push)
    else $error("pop from empty queue or pop with push");

endmodule

// ===== bench/round_robin_time_slice_scheduler_core_tb.sv =====
`timescale 1ns / 1ps
module round_robin_time_slice_scheduler_core_tb;
  import rrts_pkg::*;

  // Cycles without any accepted beat or bus access before the run is declared hung.
  localparam int QUIET_LIMIT = 20000;
  // Cycles allowed after the last expected slot before touching registers or ending.
  localparam int SETTLE_CYCLES = 300;
  localparam int NPROC = 64;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [5:0]  proc_index;
  logic [15:0] arrival_time;
  logic [15:0] burst_time;
  logic        out_valid;
  logic        out_ready;
  logic        slot_busy;
  logic [5:0]  slot_process;
  logic [31:0] time_now;
  logic        finished;
  logic [5:0]  finished_process;
  logic [31:0] finish_time;
  logic [31:0] wait_time;
  logic [31:0] turnaround_time;
  logic        all_done;

  round_robin_time_slice_scheduler_core uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .proc_index(proc_index), .arrival_time(arrival_time), .burst_time(burst_time),
    .out_valid(out_valid), .out_ready(out_ready), .slot_busy(slot_busy),
    .slot_process(slot_process), .time_now(time_now), .finished(finished),
    .finished_process(finished_process), .finish_time(finish_time),
    .wait_time(wait_time), .turnaround_time(turnaround_time), .all_done(all_done)
  );

  // One slot report as the scheduler should produce it.
  typedef struct {
    logic        busy;
    logic [5:0]  proc;
    logic [31:0] now;
    logic        fin;
    logic [5:0]  fin_proc;
    logic [31:0] fin_time;
    logic [31:0] wait_t;
    logic [31:0] turn_t;
    logic        done;
  } slot_report_t;

  slot_report_t slot_q[$];

  // Shadow copy of the scheduler state.
  logic [7:0]  sh_slice;
  logic [6:0]  sh_count;
  logic [15:0] sh_arr[NPROC];
  logic [15:0] sh_burst[NPROC];
  logic [15:0] sh_rem[NPROC];
  logic [5:0]  sh_ring[NPROC];
  int          sh_head, sh_tail, sh_fill;
  logic [5:0]  sh_cur;
  logic        sh_run;
  int          sh_used;
  logic [31:0] sh_clock;
  logic        sh_started;
  logic        last_done;

  int  errors;
  int  beats_sent;
  bit  idle_en;
  int  hold_cycles;
  int  quiet;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Shadow scheduler. The tables are cleared here only so the arrays hold known values;
  // stimulus never lets an entry below the count be read before it is loaded.
  // ---------------------------------------------------------------------------------------
  function automatic void wipe_schedule();
    for (int i = 0; i < NPROC; i++) begin
      sh_arr[i] = '0;
      sh_burst[i] = '0;
      sh_rem[i] = '0;
      sh_ring[i] = '0;
    end
    sh_head = 0;
    sh_tail = 0;
    sh_fill = 0;
    sh_cur = '0;
    sh_run = 1'b0;
    sh_used = 0;
    sh_clock = '0;
    sh_started = 1'b0;
  endfunction

  function automatic int live_entries();
    return (sh_count > NPROC) ? NPROC : int'(sh_count);
  endfunction

  function automatic void enqueue_proc(int p);
    if (sh_fill < NPROC) begin
      sh_ring[sh_tail] = p[5:0];
      sh_tail = (sh_tail + 1) % NPROC;
      sh_fill++;
    end
  endfunction

  function automatic void queue_new_arrivals();
    for (int i = 0; i < live_entries(); i++)
      if ({16'd0, sh_arr[i]} == sh_clock) enqueue_proc(i);
  endfunction

  function automatic bit work_pending();
    for (int i = 0; i < live_entries(); i++)
      if (sh_rem[i] != 0) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void step_clock();
    if (sh_clock != TIME_MAX) begin
      sh_clock++;
      queue_new_arrivals();
    end
  endfunction

  // Runs one time slot on the shadow state and returns its report.
  function automatic slot_report_t run_slot();
    slot_report_t r;
    int p;
    int quantum;
    logic [31:0] turn;
    r = '{default: '0};
    quantum = (sh_slice == 0) ? 1 : int'(sh_slice);
    if (!sh_started) begin
      sh_started = 1'b1;
      queue_new_arrivals();
    end
    if (!work_pending()) begin
      r.now = sh_clock;
      r.done = 1'b1;
      return r;
    end
    if (sh_run && sh_rem[sh_cur] == 0) sh_run = 1'b0;
    while (!sh_run && sh_fill != 0) begin
      p = int'(sh_ring[sh_head]);
      sh_head = (sh_head + 1) % NPROC;
      sh_fill--;
      if (sh_rem[p] != 0) begin
        sh_cur = p[5:0];
        sh_run = 1'b1;
        sh_used = 0;
      end
    end
    if (!sh_run) begin
      // Nobody is ready: an idle slot still moves time forward.
      step_clock();
      r.now = sh_clock;
      r.done = !work_pending();
      return r;
    end
    p = int'(sh_cur);
    sh_rem[p]--;
    sh_used++;
    step_clock();
    r.busy = 1'b1;
    r.proc = p[5:0];
    if (sh_rem[p] == 0) begin
      turn = sh_clock - {16'd0, sh_arr[p]};
      sh_run = 1'b0;
      r.fin = 1'b1;
      r.fin_proc = p[5:0];
      r.fin_time = sh_clock;
      r.wait_t = turn - {16'd0, sh_burst[p]};
      r.turn_t = turn;
    end else if (sh_used >= quantum) begin
      // The preempted process goes behind the arrivals queued by this slot.
      sh_run = 1'b0;
      enqueue_proc(p);
    end
    r.now = sh_clock;
    r.done = !work_pending();
    return r;
  endfunction

  function automatic void apply_beat(logic [1:0] cmd, logic [5:0] idx, logic [15:0] arr,
                                     logic [15:0] bst);
    slot_report_t r;
    case (cmd)
      CMD_LOAD: begin
        sh_arr[idx] = arr;
        sh_burst[idx] = bst;
        sh_rem[idx] = bst;
      end
      CMD_CLEAR: begin
        wipe_schedule();
      end
      CMD_TICK: begin
        r = run_slot();
        last_done = r.done;
        slot_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driving side.
  // ---------------------------------------------------------------------------------------
  // Sends one beat. Called at a clock edge; returns at the edge where the beat is taken,
  // leaving valid high so a back-to-back beat does not drop it.
  task automatic send_beat(logic [1:0] cmd, logic [5:0] idx, logic [15:0] arr,
                           logic [15:0] bst);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    proc_index <= idx;
    arrival_time <= arr;
    burst_time <= bst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_beat(cmd, idx, arr, bst);
    beats_sent++;
  endtask

  task automatic send_tick();
    send_beat(CMD_TICK, '0, '0, '0);
  endtask

  task automatic send_clear();
    send_beat(CMD_CLEAR, 6'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Waits for every expected slot, then lets any load still in flight finish.
  task automatic drain_schedule();
    in_valid <= 1'b0;
    @(posedge clk);
    while (slot_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Two-phase bus write; the register is taken at the access edge.
  task automatic write_reg(logic idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_SLICE) sh_slice = value[7:0];
    else sh_count = value[6:0];
  endtask

  // Clears the schedule, sets both registers and loads every entry in use.
  task automatic setup_schedule(int n, int slice, int max_arr, int max_burst);
    send_clear();
    drain_schedule();
    write_reg(REG_SLICE, slice);
    write_reg(REG_COUNT, n);
    @(posedge clk);
    for (int i = 0; i < n; i++)
      send_beat(CMD_LOAD, i[5:0], 16'($urandom_range(0, max_arr)),
                16'($urandom_range(1, max_burst)));
  endtask

  // Ticks until everything has finished, with an occasional reload of a live entry.
  task automatic tick_to_completion(int n, bit reloads);
    int cap;
    cap = 0;
    last_done = 1'b0;
    while (!last_done && cap < 4000) begin
      if (reloads && n > 0 && $urandom_range(0, 19) == 0)
        send_beat(CMD_LOAD, 6'($urandom_range(0, n - 1)),
                  16'(sh_clock + $urandom_range(1, 3)), 16'($urandom_range(1, 5)));
      else
        send_tick();
      cap++;
    end
    repeat ($urandom_range(1, 3)) send_tick();
  endtask

  // ---------------------------------------------------------------------------------------
  // Receiving side: random stalls, plus a long hold-off when a test asks for one.
  // ---------------------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  // Every accepted slot report is compared with the oldest expectation.
  always @(posedge clk) begin
    slot_report_t w;
    if (!rst && out_valid && out_ready) begin
      if (slot_q.size() == 0) begin
        report_mismatch("unexpected slot report", 32'd1, 32'd0);
      end else begin
        w = slot_q.pop_front();
        if (slot_busy !== w.busy)
          report_mismatch("slot_busy", 32'(slot_busy), 32'(w.busy));
        if (slot_process !== w.proc)
          report_mismatch("slot_process", 32'(slot_process), 32'(w.proc));
        if (time_now !== w.now) report_mismatch("time_now", time_now, w.now);
        if (finished !== w.fin) report_mismatch("finished", 32'(finished), 32'(w.fin));
        if (finished_process !== w.fin_proc)
          report_mismatch("finished_process", 32'(finished_process), 32'(w.fin_proc));
        if (finish_time !== w.fin_time) report_mismatch("finish_time", finish_time, w.fin_time);
        if (wait_time !== w.wait_t) report_mismatch("wait_time", wait_time, w.wait_t);
        if (turnaround_time !== w.turn_t)
          report_mismatch("turnaround_time", turnaround_time, w.turn_t);
        if (all_done !== w.done) report_mismatch("all_done", 32'(all_done), 32'(w.done));
      end
    end
  end

  // Watchdog: a long stretch with no beat and no bus access means the block is hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------
  // Defaults after reset: no entries in use, so the very first tick finds nothing left.
  task automatic test_reset_defaults();
    send_tick();
    send_tick();
    drain_schedule();
  endtask

  // Extreme field values are loaded and then overwritten, so every input bit toggles
  // without parking the schedule on an arrival tens of thousands of slots away.
  task automatic test_field_extremes();
    send_clear();
    drain_schedule();
    write_reg(REG_SLICE, 1);
    write_reg(REG_COUNT, 2);
    @(posedge clk);
    send_beat(CMD_LOAD, 6'd63, 16'hFFFF, 16'hFFFF);
    send_beat(CMD_LOAD, 6'd0, 16'hFFFF, 16'hFFFF);
    send_beat(CMD_LOAD, 6'd0, 16'd0, 16'd3);
    send_beat(CMD_LOAD, 6'd1, 16'd0, 16'd2);
    tick_to_completion(2, 1'b0);
    drain_schedule();
  endtask

  // Late arrival gives idle slots first; arrivals at the same time queue in index order.
  task automatic test_idle_and_order();
    send_clear();
    drain_schedule();
    write_reg(REG_SLICE, 2);
    write_reg(REG_COUNT, 3);
    @(posedge clk);
    send_beat(CMD_LOAD, 6'd2, 16'd3, 16'd4);
    send_beat(CMD_LOAD, 6'd0, 16'd3, 16'd3);
    send_beat(CMD_LOAD, 6'd1, 16'd5, 16'd1);
    tick_to_completion(3, 1'b0);
    drain_schedule();
  endtask

  // Quantum at both ends, and a full table of 64 short processes.
  task automatic test_quantum_extremes();
    setup_schedule(5, 255, 4, 6);
    tick_to_completion(5, 1'b0);
    drain_schedule();
    setup_schedule(NPROC, 1, 3, 2);
    tick_to_completion(NPROC, 1'b0);
    drain_schedule();
  endtask

  // The receiver holds off while ticks keep coming, so the block backs up its input.
  task automatic test_backpressure();
    setup_schedule(4, 2, 2, 4);
    @(posedge clk);
    hold_cycles = 1500;
    repeat (8) send_tick();
    tick_to_completion(4, 1'b0);
    drain_schedule();
  endtask

  // Mostly well-formed schedules with random content, reloads and a mid-run clear.
  task automatic test_random_schedules(int target);
    int n;
    int slice;
    while (beats_sent < target) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, NPROC) : $urandom_range(0, 8);
      case ($urandom_range(0, 3))
        0: slice = 1;
        1: slice = 255;
        default: slice = $urandom_range(1, 4);
      endcase
      setup_schedule(n, slice, $urandom_range(0, 10), (n > 16) ? 2 : $urandom_range(1, 8));
      if ($urandom_range(0, 7) == 0) begin
        // Abandon the run halfway, then reload the whole table before ticking again.
        repeat ($urandom_range(1, 6)) send_tick();
        send_clear();
        for (int i = 0; i < n; i++)
          send_beat(CMD_LOAD, i[5:0], 16'($urandom_range(0, 5)), 16'($urandom_range(1, 4)));
      end
      tick_to_completion(n, 1'b1);
      // The sender waits here until every expected report has come back.
      drain_schedule();
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    command = CMD_LOAD;
    proc_index = '0;
    arrival_time = '0;
    burst_time = '0;
    errors = 0;
    beats_sent = 0;
    hold_cycles = 0;
    quiet = 0;
    idle_en = 1'b1;
    sh_slice = 8'd2;
    sh_count = 7'd0;
    last_done = 1'b0;
    wipe_schedule();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_idle_and_order();
    test_quantum_extremes();
    test_backpressure();
    test_random_schedules(850);
    idle_en = 1'b0;
    test_random_schedules(1000);

    in_valid <= 1'b0;
    @(posedge clk);
    while (slot_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (slot_q.size() != 0) report_mismatch("reports never delivered", slot_q.size(), 0);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
